/* rtl/gb2u_pkg.sv */
// ----------------------------------------------------------------------------
// gb2u_pkg
// Shared types and constants for the GB2312 to UCS-2 stream converter.
// ----------------------------------------------------------------------------
`default_nettype none

package gb2u_pkg;

  localparam int unsigned MapEntries = 7614;
  localparam int unsigned MapAw      = $clog2(MapEntries);
  localparam int unsigned RowLen     = 94;

  localparam logic [7:0] TrailLo  = 8'hA1;
  localparam logic [7:0] TrailHi  = 8'hFE;
  localparam logic [7:0] Lead1Lo  = 8'hA1;
  localparam logic [7:0] Lead1Hi  = 8'hA9;
  localparam logic [7:0] Lead2Lo  = 8'hB0;
  localparam logic [7:0] Lead2Hi  = 8'hF7;
  localparam logic [6:0] Lead2Row0 = 7'd9;

  localparam logic [15:0] ReplReset = 16'hA1BC;

  // Item function codes
  localparam logic FuncConvert = 1'b0;
  localparam logic FuncLoad    = 1'b1;

  // Configuration register indexes
  localparam logic RegReplacement = 1'b0;

  typedef struct packed {
    logic        func;
    logic [7:0]  data_byte;
    logic [12:0] table_index;
    logic [15:0] table_word;
  } in_item_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        was_invalid;
  } out_item_t;

  // Per-transfer control from the decoder to the lookup pipeline
  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    logic [MapAw-1:0]  addr;
    logic [15:0]       wdata;
    logic              emit;
    logic              use_ram;
    logic              bad;
    logic [15:0]       code;
  } lookup_t;

endpackage

`default_nettype wire

/* rtl/gb2u_ram.sv */
// ----------------------------------------------------------------------------
// gb2u_ram
// Generic single-clock RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module gb2u_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* rtl/gb2u_decode.sv */
// ----------------------------------------------------------------------------
// gb2u_decode
// Lead byte tracking and table index calculation for each accepted item.
// ----------------------------------------------------------------------------
`default_nettype none

module gb2u_decode (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              accept,
  input  wire gb2u_pkg::in_item_t item,
  input  wire logic [15:0]       repl_code,
  output gb2u_pkg::lookup_t      ctl
);

  logic       lead_pending_r, lead_pending_nxt;
  logic [7:0] lead_byte_r, lead_byte_nxt;

  logic       is_load;
  logic       trail_ok, lead1, lead2;
  logic [6:0] row;
  logic [gb2u_pkg::MapAw-1:0] idx;

  always_comb begin
    is_load  = (item.func == gb2u_pkg::FuncLoad);
    trail_ok = (item.data_byte >= gb2u_pkg::TrailLo) && (item.data_byte <= gb2u_pkg::TrailHi);
    lead1    = (lead_byte_r >= gb2u_pkg::Lead1Lo) && (lead_byte_r <= gb2u_pkg::Lead1Hi);
    lead2    = (lead_byte_r >= gb2u_pkg::Lead2Lo) && (lead_byte_r <= gb2u_pkg::Lead2Hi);
    if (lead1) begin
      row = 7'(lead_byte_r - gb2u_pkg::Lead1Lo);
    end else begin
      row = 7'(lead_byte_r - gb2u_pkg::Lead2Lo) + gb2u_pkg::Lead2Row0;
    end
    // Rows top out at 80, so the index stays inside the table for every pair that issues a read
    idx = gb2u_pkg::MapAw'(row) * gb2u_pkg::MapAw'(gb2u_pkg::RowLen)
        + gb2u_pkg::MapAw'(item.data_byte - gb2u_pkg::TrailLo);
  end

  always_comb begin
    ctl         = '0;
    ctl.wdata   = item.table_word;
    ctl.addr    = is_load ? item.table_index : idx;
    ctl.wr_en   = accept && is_load &&
                  (item.table_index < gb2u_pkg::MapAw'(gb2u_pkg::MapEntries));
    ctl.code    = {8'h00, item.data_byte};
    if (accept && !is_load) begin
      if (lead_pending_r) begin
        ctl.emit = 1'b1;
        if (trail_ok && (lead1 || lead2)) begin
          ctl.rd_en   = 1'b1;
          ctl.use_ram = 1'b1;
        end else begin
          ctl.bad  = 1'b1;
          ctl.code = repl_code;
        end
      end else if (!item.data_byte[7]) begin
        ctl.emit = 1'b1;
      end
    end
  end

  always_comb begin
    lead_pending_nxt = lead_pending_r;
    lead_byte_nxt    = lead_byte_r;
    if (accept && !is_load) begin
      if (lead_pending_r) begin
        lead_pending_nxt = 1'b0;
        lead_byte_nxt    = 8'h00;
      end else if (item.data_byte[7]) begin
        lead_pending_nxt = 1'b1;
        lead_byte_nxt    = item.data_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_pending_r <= 1'b0;
      lead_byte_r    <= 8'h00;
    end else begin
      lead_pending_r <= lead_pending_nxt;
      lead_byte_r    <= lead_byte_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/gb2312_to_ucs2_stream.sv */
// ----------------------------------------------------------------------------
// gb2312_to_ucs2_stream
// GB2312 byte stream to UCS-2 code units, table held in on-chip RAM.
// ----------------------------------------------------------------------------
// Pipeline: a result passes the lookup stage and the output register before it is valid.
// Throughput: one byte or table load per cycle while the output is not stalled;
//   the table RAM gives one read and one write each cycle.
// Reset: synchronous, active low; clears lead byte state, pipeline valids and
//   sets the replacement code to A1BC. Table contents are undefined until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module gb2312_to_ucs2_stream (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire gb2u_pkg::in_item_t in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output gb2u_pkg::out_item_t     out_data,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  logic [15:0] repl_r;
  logic        accept;
  gb2u_pkg::lookup_t ctl;
  logic [15:0] ram_rdata;

  // lookup stage, waiting on the RAM read
  logic        s1_valid_r, s1_valid_nxt;
  logic        s1_use_ram_r, s1_bad_r;
  logic [15:0] s1_code_r;
  logic        s1_adv;

  logic                out_valid_r, out_valid_nxt;
  gb2u_pkg::out_item_t out_data_r;

  // ---- configuration ----
  assign pready = 1'b1;
  assign prdata = {16'h0000, repl_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      repl_r <= gb2u_pkg::ReplReset;
    end else if (psel && penable && pwrite && (paddr[2] == gb2u_pkg::RegReplacement)) begin
      repl_r <= pwdata[15:0];
    end
  end

  // ---- decode and table ----
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign accept   = in_valid && in_ready;

  gb2u_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .item      (in_data),
    .repl_code (repl_r),
    .ctl       (ctl)
  );

  // read data holds while the lookup stage stalls, as no new read is issued
  gb2u_ram #(
    .WIDTH (16),
    .DEPTH (gb2u_pkg::MapEntries)
  ) u_map_ram (
    .clk   (clk),
    .we    (ctl.wr_en),
    .waddr (ctl.addr),
    .wdata (ctl.wdata),
    .re    (ctl.rd_en),
    .raddr (ctl.addr),
    .rdata (ram_rdata)
  );

  // ---- pipeline ----
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    if (accept) begin
      s1_valid_nxt = ctl.emit;
    end
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_use_ram_r <= ctl.use_ram;
      s1_bad_r     <= ctl.bad;
      s1_code_r    <= ctl.code;
    end
    if (s1_adv) begin
      out_data_r.code_unit   <= s1_use_ram_r ? ram_rdata : s1_code_r;
      out_data_r.was_invalid <= s1_bad_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire
